// File: sv/gn2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants and the quarter-wave sine function of the 2D gradient noise.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INT_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF = 10;
  localparam int OUT_BITS_DEF   = 16;

  localparam logic [31:0] HMUL_A = 32'd3284157443;
  localparam logic [31:0] HMUL_B = 32'd1911520717;
  localparam logic [31:0] HMUL_C = 32'd2048419325;

  // Q30 sine polynomial coefficients, C1 first
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [31:0] SIN_C11 = 32'd3864;

  // quarter-wave entry k in Q1.15; elaborated into a constant table
  function automatic logic [15:0] quarter_sine(input logic [31:0] k, input int phase_bits);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] s;
    logic [63:0] r;
    t  = {32'd0, k} << (32 - phase_bits);
    t2 = (t * t) >> 30;
    s  = {32'd0, SIN_C11};
    s  = {32'd0, SIN_C9} - ((s * t2) >> 30);
    s  = {32'd0, SIN_C7} - ((s * t2) >> 30);
    s  = {32'd0, SIN_C5} - ((s * t2) >> 30);
    s  = {32'd0, SIN_C3} - ((s * t2) >> 30);
    s  = {32'd0, SIN_C1} - ((s * t2) >> 30);
    r  = (s * t) >> 30;
    r  = (r * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/gradient_noise_2d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D Perlin gradient noise, one point in and one value out per cycle unless the output stalls.
//
//   channel  signals                          payload
//   in       in_valid / in_ready              coord_x, coord_y
//   out      out_valid / out_ready            noise_value
//
// One point per cycle sustained while the output is not stalled; the pipeline
// runs through hash multiplies, table, dot products, two blend levels, rounding.
// All stages advance together when the output register is free or taken.
// Reset clears only the stage valid bits.
// A stall holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
  parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS   = gn2d_pkg::INT_BITS_DEF,
  parameter int PHASE_BITS = gn2d_pkg::PHASE_BITS_DEF,
  parameter int OUT_BITS   = gn2d_pkg::OUT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                coord_x,
  input  wire logic [31:0]                coord_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [OUT_BITS-1:0]      noise_value
);

  localparam int NSTG = 10;
  localparam int FSH  = 24 - FRAC_BITS;

  logic en;
  logic [NSTG-1:0] vld;

  // pipeline moves when the last stage is empty or being taken
  assign en        = !vld[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTG-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 0: split coordinates
  logic [31:0] x0;
  logic [31:0] y0;
  logic [24:0] tx0;
  logic [24:0] ty0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= 32'((coord_x >> FRAC_BITS) & ((64'd1 << INT_BITS) - 64'd1));
      y0  <= 32'((coord_y >> FRAC_BITS) & ((64'd1 << INT_BITS) - 64'd1));
      tx0 <= 25'(coord_x[FRAC_BITS-1:0]) << FSH;
      ty0 <= 25'(coord_y[FRAC_BITS-1:0]) << FSH;
    end
  end

  // corner gradients, four stages after stage 0
  logic signed [16:0] gx [4];
  logic signed [16:0] gy [4];
  logic [31:0] ci [4];
  logic [31:0] cj [4];

  assign ci[0] = x0;        assign cj[0] = y0;
  assign ci[1] = x0 + 32'd1; assign cj[1] = y0;
  assign ci[2] = x0;        assign cj[2] = y0 + 32'd1;
  assign ci[3] = x0 + 32'd1; assign cj[3] = y0 + 32'd1;

  for (genvar c = 0; c < 4; c++) begin : g_corner
    gn2d_corner #(.PHASE_BITS(PHASE_BITS)) u_corner (
      .clk (clk),
      .en  (en),
      .ci  (ci[c]),
      .cj  (cj[c]),
      .gx  (gx[c]),
      .gy  (gy[c])
    );
  end

  // fraction delay line alongside the hash; smoothstep computed on the way
  logic [24:0] txd [4];
  logic [24:0] tyd [4];
  logic [24:0] tx2;
  logic [24:0] ty2;
  logic [24:0] wx;
  logic [24:0] wy;
  logic [49:0] tx_sq;
  logic [49:0] ty_sq;
  logic [49:0] wx_p;
  logic [49:0] wy_p;
  logic [26:0] tx_k;
  logic [26:0] ty_k;

  assign tx_sq = txd[0] * txd[0];
  assign ty_sq = tyd[0] * tyd[0];
  assign tx_k  = 27'(3 << 24) - {1'b0, txd[1], 1'b0};
  assign ty_k  = 27'(3 << 24) - {1'b0, tyd[1], 1'b0};
  assign wx_p  = 50'(tx2) * 50'(tx_k);
  assign wy_p  = 50'(ty2) * 50'(ty_k);

  always_ff @(posedge clk) begin
    if (en) begin
      txd[0] <= tx0;   tyd[0] <= ty0;
      for (int s = 1; s < 4; s++) begin
        txd[s] <= txd[s-1];
        tyd[s] <= tyd[s-1];
      end
      tx2 <= tx_sq[48:24];
      ty2 <= ty_sq[48:24];
      wx  <= wx_p[48:24];
      wy  <= wy_p[48:24];
    end
  end

  // weights held to the blend stages
  logic [24:0] wx_d [2];
  logic [24:0] wy_d [4];
  always_ff @(posedge clk) begin
    if (en) begin
      wx_d[0] <= wx; wy_d[0] <= wy;
      wx_d[1] <= wx_d[0]; wy_d[1] <= wy_d[0];
      wy_d[2] <= wy_d[1];
      wy_d[3] <= wy_d[2];
    end
  end

  // stage 5: dot products, Q39 rounded into Q30
  logic signed [25:0] dxs [4];
  logic signed [25:0] dys [4];
  logic signed [43:0] prod [4];
  logic signed [33:0] dot [4];

  assign dxs[0] = signed'({1'b0, txd[3]});
  assign dxs[2] = dxs[0];
  assign dxs[1] = dxs[0] - 26'sd16777216;
  assign dxs[3] = dxs[1];
  assign dys[0] = signed'({1'b0, tyd[3]});
  assign dys[1] = dys[0];
  assign dys[2] = dys[0] - 26'sd16777216;
  assign dys[3] = dys[2];

  for (genvar c = 0; c < 4; c++) begin : g_dot
    assign prod[c] = 44'(dxs[c]) * 44'(gx[c]) + 44'(dys[c]) * 44'(gy[c]) + 44'sd256;
    always_ff @(posedge clk) begin
      if (en) begin
        dot[c] <= 34'(prod[c] >>> 9);
      end
    end
  end

  // stage 6-7: blend along x
  logic signed [34:0] dx_a [2];
  logic signed [59:0] mx   [2];
  logic signed [34:0] bx_a [2];
  logic signed [34:0] rx   [2];

  assign dx_a[0] = 35'(dot[1]) - 35'(dot[0]);
  assign dx_a[1] = 35'(dot[3]) - 35'(dot[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        mx[k]   <= 60'(dx_a[k]) * 60'(signed'({1'b0, wx_d[1]}));
        bx_a[k] <= 35'(dot[2*k]);
        rx[k]   <= bx_a[k] + 35'(mx[k] >>> 24);
      end
    end
  end

  // stage 8-9: blend along y, then round and saturate
  logic signed [35:0] dy_a;
  logic signed [61:0] my;
  logic signed [35:0] by_a;
  logic signed [36:0] r;
  logic signed [36:0] v;
  localparam logic signed [36:0] VMAX = 37'sd1 <<< (OUT_BITS - 1);

  assign dy_a = 36'(rx[1]) - 36'(rx[0]);
  assign r    = 37'(by_a) + 37'(my >>> 24);
  assign v    = (r + (37'sd1 <<< (30 - OUT_BITS))) >>> (31 - OUT_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      my   <= 62'(dy_a) * 62'(signed'({1'b0, wy_d[3]}));
      by_a <= 36'(rx[0]);
      if (v > VMAX - 37'sd1) begin
        noise_value <= OUT_BITS'(VMAX - 37'sd1);
      end else if (v < -VMAX) begin
        noise_value <= OUT_BITS'(-VMAX);
      end else begin
        noise_value <= OUT_BITS'(v);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/gn2d_corner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_corner
// Pipelined corner hash and gradient pick for one lattice corner. Three
// multiply stages, then a table stage. Advances when en is high.
// ----------------------------------------------------------------------------
module gn2d_corner #(
  parameter int PHASE_BITS = gn2d_pkg::PHASE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [31:0] ci,
  input  wire logic        [31:0] cj,
  output logic signed [16:0] gx,
  output logic signed [16:0] gy
);

  localparam int QSTEPS = 1 << (PHASE_BITS - 2);
  localparam int IDX_BITS = PHASE_BITS - 2;

  // constant quarter-wave table, one extra entry for the top of the quadrant
  logic [15:0] sine_rom [QSTEPS+1];
  for (genvar g = 0; g <= QSTEPS; g++) begin : g_rom
    assign sine_rom[g] = gn2d_pkg::quarter_sine(32'(g), PHASE_BITS);
  end

  logic [31:0] a1;
  logic [31:0] j1;
  logic [31:0] b2;
  logic [31:0] a2;
  logic [31:0] h3;
  logic [31:0] b_mix;
  logic [31:0] a_mix;

  assign b_mix = j1 ^ {a1[15:0], a1[31:16]};
  assign a_mix = a2 ^ {b2[15:0], b2[31:16]};

  // hash stages: one multiply each
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= ci * gn2d_pkg::HMUL_A;
      j1 <= cj;
      b2 <= b_mix * gn2d_pkg::HMUL_B;
      a2 <= a1;
      h3 <= a_mix * gn2d_pkg::HMUL_C;
    end
  end

  logic [PHASE_BITS-1:0] phase;
  logic [1:0]            quad;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS:0]     idx_hi;
  logic signed [16:0]    lo;
  logic signed [16:0]    hi;

  assign phase  = h3[31 -: PHASE_BITS];
  assign quad   = phase[PHASE_BITS-1 -: 2];
  assign idx    = phase[IDX_BITS-1:0];
  assign idx_hi = (IDX_BITS+1)'(QSTEPS) - {1'b0, idx};
  assign lo     = signed'({1'b0, sine_rom[{1'b0, idx}]});
  assign hi     = signed'({1'b0, sine_rom[idx_hi]});

  // gradient by quadrant symmetry
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad)
        2'd0: begin gx <= lo;  gy <= hi;  end
        2'd1: begin gx <= hi;  gy <= -lo; end
        2'd2: begin gx <= -lo; gy <= -hi; end
        default: begin gx <= -hi; gy <= lo; end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/gn2d_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks on the noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn2d_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // input is ready whenever the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready low with empty output");

  // stall on output stalls input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken in stall");

  // no result straight after reset
  a_rst: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result after reset");

endmodule

bind gradient_noise_2d gn2d_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
`default_nettype wire
